/* design/iaid_pkg.sv */
`timescale 1ns / 1ps

package iaid_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned WORD_BITS_DEF = 32;

  // field widths of the stream items
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FIDX_W = 6;
  localparam int unsigned REM_W  = 7;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 7;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  // input tdata offsets
  localparam int unsigned IN_CMD_LSB  = 0;
  localparam int unsigned IN_POS_LSB  = IN_CMD_LSB + CMD_W;
  localparam int unsigned IN_WORD_LSB = IN_POS_LSB + POS_W;

  // output tdata offsets
  localparam int unsigned OUT_RD_LSB    = 0;
  localparam int unsigned OUT_FIDX_LSB  = OUT_RD_LSB + WORD_W;
  localparam int unsigned OUT_REM_LSB   = OUT_FIDX_LSB + FIDX_W;
  localparam int unsigned OUT_ST_LSB    = OUT_REM_LSB + REM_W;
  localparam int unsigned OUT_CNT_LSB   = OUT_ST_LSB + ST_W;
  localparam int unsigned OUT_EMPTY_LSB = OUT_CNT_LSB + CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ_AT = 3'd0,
    CMD_PUSH    = 3'd1,
    CMD_POP     = 3'd2,
    CMD_INSERT  = 3'd3,
    CMD_PREPEND = 3'd4,
    CMD_DELETE  = 3'd5,
    CMD_REMOVE  = 3'd6,
    CMD_FIND    = 3'd7
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } st_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_UP,
    S_PUT,
    S_DOWN,
    S_COMPACT,
    S_FIND,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    DP_IDLE,
    DP_LATCH,
    DP_SET_RANGE,
    DP_SET_FULL,
    DP_SET_NONE,
    DP_READ_AT,
    DP_PUSH,
    DP_POP,
    DP_TAKE,
    DP_UP_START,
    DP_UP,
    DP_PUT,
    DP_DEL_LAST,
    DP_DOWN_START,
    DP_DOWN,
    DP_SCAN_START,
    DP_COMPACT,
    DP_FIND
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic pos_eq_cnt;
    logic pos_is_last;
    logic cnt_zero;
    logic cnt_full;
    logic up_more;
    logic down_more;
    logic scan_more;
    logic match;
  } dp_stat_t;

endpackage

/* design/iaid_dpath.sv */
`timescale 1ns / 1ps

module iaid_dpath #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [iaid_pkg::IN_DATA_W-1:0]   in_data_i,
  input  iaid_pkg::dp_cmd_t                cmd_i,
  output iaid_pkg::dp_stat_t               stat_o,
  output logic [iaid_pkg::OUT_DATA_W-1:0]  out_data_o
);
  import iaid_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [WORD_BITS-1:0] mem_q [CAPACITY];

  cmd_e                 cmd_q, cmd_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [WORD_BITS-1:0] val_q, val_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        wptr_q, wptr_d;
  logic [WORD_BITS-1:0] rdat_q;
  logic [WORD_W-1:0]    rd_q, rd_d;
  logic [FIDX_W-1:0]    fidx_q, fidx_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  st_e                  st_q, st_d;
  logic [OUT_DATA_W-1:0] out_q;

  logic                 mem_we;
  logic [XW-1:0]        waddr_x, raddr_x;
  logic [WORD_BITS-1:0] wdata;

  logic [XW-1:0]        pos_x, cnt_x, ptr_x, wptr_x;
  logic                 match;
  logic signed [WORD_W-1:0] in_word;
  logic [63:0]          in_word64;
  logic [63:0]          rd_ext;

  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(count_q);
  assign ptr_x  = XW'(ptr_q);
  assign wptr_x = XW'(wptr_q);
  assign match  = (rdat_q == val_q);

  assign in_word   = signed'(in_data_i[IN_WORD_LSB +: WORD_W]);
  assign in_word64 = 64'(in_word);
  assign rd_ext    = 64'(signed'(rdat_q));

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.pos_gt_cnt  = (pos_x > cnt_x);
    stat_o.pos_ge_cnt  = (pos_x >= cnt_x);
    stat_o.pos_eq_cnt  = (pos_x == cnt_x);
    stat_o.pos_is_last = ((pos_x + XW'(1)) == cnt_x);
    stat_o.cnt_zero    = (count_q == '0);
    stat_o.cnt_full    = (cnt_x >= XW'(CAPACITY));
    stat_o.up_more     = (ptr_x > (pos_x + XW'(1)));
    stat_o.down_more   = ((ptr_x + XW'(2)) < cnt_x);
    stat_o.scan_more   = (ptr_x < cnt_x);
    stat_o.match       = match;
  end

  always_comb begin
    cmd_d   = cmd_q;
    pos_d   = pos_q;
    val_d   = val_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    wptr_d  = wptr_q;
    rd_d    = rd_q;
    fidx_d  = fidx_q;
    rem_d   = rem_q;
    st_d    = st_q;
    mem_we  = 1'b0;
    waddr_x = cnt_x;
    wdata   = val_q;
    raddr_x = ptr_x;
    case (cmd_i.op)
      DP_LATCH: begin
        cmd_d  = cmd_e'(in_data_i[IN_CMD_LSB +: CMD_W]);
        pos_d  = (cmd_d == CMD_PREPEND) ? '0 : in_data_i[IN_POS_LSB +: POS_W];
        val_d  = in_word64[WORD_BITS-1:0];
        rd_d   = '0;
        fidx_d = '0;
        rem_d  = '0;
        st_d   = ST_OK;
      end
      DP_SET_RANGE: st_d = ST_RANGE;
      DP_SET_FULL:  st_d = ST_FULL;
      DP_SET_NONE:  st_d = ST_NONE;
      DP_READ_AT:   raddr_x = pos_x;
      DP_PUSH: begin
        mem_we  = 1'b1;
        waddr_x = cnt_x;
        wdata   = val_q;
        count_d = count_q + CW'(1);
      end
      DP_POP: begin
        raddr_x = cnt_x - XW'(1);
        count_d = count_q - CW'(1);
      end
      DP_TAKE: rd_d = rd_ext[WORD_W-1:0];
      DP_UP_START: begin
        raddr_x = cnt_x - XW'(1);
        ptr_d   = count_q;
      end
      DP_UP: begin
        // move one entry up, fetch the one below the next gap
        mem_we  = 1'b1;
        waddr_x = ptr_x;
        wdata   = rdat_q;
        raddr_x = ptr_x - XW'(2);
        ptr_d   = ptr_q - CW'(1);
      end
      DP_PUT: begin
        mem_we  = 1'b1;
        waddr_x = pos_x;
        wdata   = val_q;
        count_d = count_q + CW'(1);
      end
      DP_DEL_LAST: count_d = count_q - CW'(1);
      DP_DOWN_START: begin
        raddr_x = pos_x + XW'(1);
        ptr_d   = pos_x[CW-1:0];
      end
      DP_DOWN: begin
        mem_we  = 1'b1;
        waddr_x = ptr_x;
        wdata   = rdat_q;
        raddr_x = ptr_x + XW'(2);
        ptr_d   = ptr_q + CW'(1);
        if (!stat_o.down_more) begin
          count_d = count_q - CW'(1);
        end
      end
      DP_SCAN_START: begin
        raddr_x = '0;
        ptr_d   = CW'(1);
        wptr_d  = '0;
        if (cmd_q == CMD_FIND) begin
          st_d = ST_NONE;
        end
      end
      DP_COMPACT: begin
        // rdat_q holds entry ptr-1; keepers are packed down at wptr
        if (!match) begin
          mem_we  = 1'b1;
          waddr_x = wptr_x;
          wdata   = rdat_q;
          wptr_d  = wptr_q + CW'(1);
        end
        raddr_x = ptr_x;
        ptr_d   = ptr_q + CW'(1);
        if (!stat_o.scan_more) begin
          count_d = wptr_d;
          rem_d   = REM_W'(count_q - wptr_d);
        end
      end
      DP_FIND: begin
        raddr_x = ptr_x;
        ptr_d   = ptr_q + CW'(1);
        if (match) begin
          fidx_d = FIDX_W'(ptr_q - CW'(1));
          st_d   = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr_x[AW-1:0]] <= wdata;
    end
    rdat_q <= mem_q[raddr_x[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    ptr_q  <= ptr_d;
    wptr_q <= wptr_d;
    rd_q   <= rd_d;
    fidx_q <= fidx_d;
    rem_q  <= rem_d;
    st_q   <= st_d;
    if (cmd_i.out_load) begin
      out_q <= {1'b0, (count_q == '0), CNT_W'(count_q), st_q, rem_q, fidx_q, rd_q};
    end
  end

  assign out_data_o = out_q;

endmodule

/* design/iaid_ctrl.sv */
`timescale 1ns / 1ps

module iaid_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  iaid_pkg::dp_stat_t  stat_i,
  output iaid_pkg::dp_cmd_t   cmd_o
);
  import iaid_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  dp_op_e decide_op;
  state_e decide_next;

  assign slot_free = !out_valid_q || out_ready_i;

  // branch taken once the transaction fields are registered
  always_comb begin
    decide_op   = DP_IDLE;
    decide_next = S_DONE;
    case (stat_i.cmd)
      CMD_READ_AT: begin
        if (stat_i.pos_ge_cnt) begin
          decide_op = DP_SET_RANGE;
        end else begin
          decide_op   = DP_READ_AT;
          decide_next = S_READ;
        end
      end
      CMD_PUSH: begin
        decide_op = stat_i.cnt_full ? DP_SET_FULL : DP_PUSH;
      end
      CMD_POP: begin
        if (stat_i.cnt_zero) begin
          decide_op = DP_SET_RANGE;
        end else begin
          decide_op   = DP_POP;
          decide_next = S_READ;
        end
      end
      CMD_INSERT, CMD_PREPEND: begin
        if (stat_i.pos_gt_cnt) begin
          decide_op = DP_SET_RANGE;
        end else if (stat_i.cnt_full) begin
          decide_op = DP_SET_FULL;
        end else if (stat_i.pos_eq_cnt) begin
          decide_op = DP_PUT;
        end else begin
          decide_op   = DP_UP_START;
          decide_next = S_UP;
        end
      end
      CMD_DELETE: begin
        if (stat_i.pos_ge_cnt) begin
          decide_op = DP_SET_RANGE;
        end else if (stat_i.pos_is_last) begin
          decide_op = DP_DEL_LAST;
        end else begin
          decide_op   = DP_DOWN_START;
          decide_next = S_DOWN;
        end
      end
      CMD_REMOVE: begin
        if (!stat_i.cnt_zero) begin
          decide_op   = DP_SCAN_START;
          decide_next = S_COMPACT;
        end
      end
      CMD_FIND: begin
        if (stat_i.cnt_zero) begin
          decide_op = DP_SET_NONE;
        end else begin
          decide_op   = DP_SCAN_START;
          decide_next = S_FIND;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE:  state_d = decide_next;
      S_READ:    state_d = S_DONE;
      S_UP:      if (!stat_i.up_more) state_d = S_PUT;
      S_PUT:     state_d = S_DONE;
      S_DOWN:    if (!stat_i.down_more) state_d = S_DONE;
      S_COMPACT: if (!stat_i.scan_more) state_d = S_DONE;
      S_FIND:    if (stat_i.match || !stat_i.scan_more) state_d = S_DONE;
      S_DONE:    if (slot_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.op        = DP_IDLE;
    cmd_o.out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LATCH;
        end
      end
      S_DECIDE:  cmd_o.op = decide_op;
      S_READ:    cmd_o.op = DP_TAKE;
      S_UP:      cmd_o.op = DP_UP;
      S_PUT:     cmd_o.op = DP_PUT;
      S_DOWN:    cmd_o.op = DP_DOWN;
      S_COMPACT: cmd_o.op = DP_COMPACT;
      S_FIND:    cmd_o.op = DP_FIND;
      S_DONE:    cmd_o.out_load = slot_free;
      default:   ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/indexed_array_insert_delete.sv */
`timescale 1ns / 1ps

// ordered array of signed words with a live count, worked on one command at a time. a command
// is taken while the block is idle, also while the previous result still waits in the output
// register. the array sits in a single-port-write, registered-read memory, so the shifting
// commands move one entry per cycle, and find stops at its first match. after reset the block
// is ready at once: entries are only ever read below the live count, so the memory needs no
// clearing.
module indexed_array_insert_delete #(
  parameter int unsigned CAPACITY  = iaid_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = iaid_pkg::WORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // command[2:0], position[9:3], word[41:10], zero pad[47:42]
  input  logic [iaid_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_word[31:0], found_index[37:32], removed_count[44:38], status[46:45],
  // entry_count[53:47], is_empty[54], zero pad[55]
  output logic [iaid_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import iaid_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  iaid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  iaid_dpath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_data_o (m_axis_tdata)
  );

  // one transaction in flight at a time
  a_single_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command accepted while busy");

  // result register never overwritten while still held
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // no append beyond capacity
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == DP_PUSH || dp_cmd.op == DP_PUT) |-> !dp_stat.cnt_full)
    else $error("write past capacity");

  // read data is taken in the cycle after its fetch
  a_take_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.op == DP_TAKE |-> ($past(dp_cmd.op) == DP_READ_AT || $past(dp_cmd.op) == DP_POP))
    else $error("read data taken without fetch");

endmodule
